### sv/uhb_pkg.sv
`default_nettype none

package uhb_pkg;

  // Fixed field widths.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned WIDX_W  = 4;
  localparam int unsigned FLEN_W  = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TTL      = 1'd1;

  localparam logic [BYTE_W-1:0] TTL_RESET = 8'd64;

  // Header constants.
  localparam logic [WORD_W-1:0] IPV4_VER_IHL  = 16'h4500;
  localparam logic [WORD_W-1:0] IPV4_FLAGS_DF = 16'h4000;
  localparam logic [BYTE_W-1:0] PROTO_UDP     = 8'd17;
  localparam logic [LEN_W-1:0]  HDR_BYTES     = 16'd28;
  localparam logic [LEN_W-1:0]  UDP_HDR_BYTES = 16'd8;

  // Header word positions.
  localparam logic [WIDX_W-1:0] W_VER_TOS   = 4'd0;
  localparam logic [WIDX_W-1:0] W_TOTAL_LEN = 4'd1;
  localparam logic [WIDX_W-1:0] W_IDENT     = 4'd2;
  localparam logic [WIDX_W-1:0] W_FLAGS     = 4'd3;
  localparam logic [WIDX_W-1:0] W_TTL_PROTO = 4'd4;
  localparam logic [WIDX_W-1:0] W_IP_CSUM   = 4'd5;
  localparam logic [WIDX_W-1:0] W_SRC_HI    = 4'd6;
  localparam logic [WIDX_W-1:0] W_SRC_LO    = 4'd7;
  localparam logic [WIDX_W-1:0] W_DST_HI    = 4'd8;
  localparam logic [WIDX_W-1:0] W_DST_LO    = 4'd9;
  localparam logic [WIDX_W-1:0] W_SPORT     = 4'd10;
  localparam logic [WIDX_W-1:0] W_DPORT     = 4'd11;
  localparam logic [WIDX_W-1:0] W_UDP_LEN   = 4'd12;
  localparam logic [WIDX_W-1:0] W_UDP_CSUM  = 4'd13;

  // Both checksums gather ten terms, one per cycle.
  localparam logic [WIDX_W-1:0] LAST_SUM_TERM = 4'd9;

  // Depth of the packet queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // Everything the back end needs to build one header.
  typedef struct packed {
    logic [LEN_W-1:0]  plen;
    logic [WORD_W-1:0] pay_sum;
    logic              too_long;
    logic [WORD_W-1:0] sport;
    logic [WORD_W-1:0] dport;
    logic [ADDR_W-1:0] dst_ip;
  } pkt_desc_t;

  // Ones-complement add with the end-around carry folded back in.
  function automatic logic [WORD_W-1:0] fold_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
  endfunction

  // Complement, with an all-zero result sent as all ones.
  function automatic logic [WORD_W-1:0] finish_sum(input logic [WORD_W-1:0] acc);
    logic [WORD_W-1:0] r;
    r = ~acc;
    return (r == '0) ? '1 : r;
  endfunction

endpackage

`default_nettype wire

### sv/uhb_front.sv
`default_nettype none

module uhb_front import uhb_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 1472
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  input  wire logic              has_byte_i,
  input  wire logic              last_i,
  input  wire logic [WORD_W-1:0] sport_i,
  input  wire logic [WORD_W-1:0] dport_i,
  input  wire logic [ADDR_W-1:0] dst_ip_i,
  output logic                   push_o,
  output pkt_desc_t              desc_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

  logic [WORD_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [BYTE_W-1:0] held_q, held_d;
  logic              odd_q, odd_d;
  logic              ovf_q, ovf_d;

  logic              take;
  logic [WORD_W-1:0] pair;
  logic [WORD_W-1:0] tail;
  logic [CNT_W-1:0]  plen;

  always_comb begin
    take = has_byte_i && (count_q < CNT_W'(MAX_PAYLOAD));
    pair = {held_q, data_byte_i};

    sum_d   = sum_q;
    count_d = count_q;
    held_d  = held_q;
    odd_d   = odd_q;
    ovf_d   = ovf_q;

    // The word that completes the sum as if the packet ended here, padded
    // with a zero low byte where a byte is left over.
    if (take) begin
      tail = odd_q ? pair : {data_byte_i, {BYTE_W{1'b0}}};
      plen = count_q + 1'b1;
    end else begin
      tail = odd_q ? {held_q, {BYTE_W{1'b0}}} : '0;
      plen = count_q;
    end

    if (accept_i) begin
      if (take) begin
        if (odd_q) begin
          sum_d  = fold_add(sum_q, pair);
          odd_d  = 1'b0;
          held_d = '0;
        end else begin
          held_d = data_byte_i;
          odd_d  = 1'b1;
        end
        count_d = count_q + 1'b1;
      end else if (has_byte_i) begin
        ovf_d = 1'b1;
      end
      if (last_i) begin
        sum_d   = '0;
        count_d = '0;
        held_d  = '0;
        odd_d   = 1'b0;
        ovf_d   = 1'b0;
      end
    end

    push_o          = accept_i && last_i;
    desc_o.plen     = LEN_W'(plen);
    desc_o.pay_sum  = fold_add(sum_q, tail);
    desc_o.too_long = ovf_q || (has_byte_i && !take);
    desc_o.sport    = sport_i;
    desc_o.dport    = dport_i;
    desc_o.dst_ip   = dst_ip_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      held_q  <= '0;
      odd_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      held_q  <= held_d;
      odd_q   <= odd_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

### sv/uhb_queue.sv
`default_nettype none

module uhb_queue import uhb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire pkt_desc_t  push_data_i,
  input  wire logic       pop_i,
  output pkt_desc_t       pop_data_o,
  output logic            full_o,
  output logic            empty_o
);

  pkt_desc_t           entry_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]     count_q;

  assign full_o     = (count_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/uhb_back.sv
`default_nettype none

module uhb_back import uhb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ADDR_W-1:0] local_ip_i,
  input  wire logic [BYTE_W-1:0] ttl_i,
  input  wire logic              q_empty_i,
  input  wire pkt_desc_t         q_data_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [WORD_W-1:0]      header_word_o,
  output logic [WIDX_W-1:0]      word_index_o,
  output logic [FLEN_W-1:0]      frame_length_o,
  output logic                   too_long_o,
  output logic                   last_word_o
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SUM  = 3'b010,
    B_EMIT = 3'b100
  } back_state_e;

  back_state_e       state_q, state_d;
  pkt_desc_t         job_q;
  logic [WIDX_W-1:0] idx_q, idx_d;
  logic [WORD_W-1:0] ip_acc_q, ip_acc_d;
  logic [WORD_W-1:0] udp_acc_q, udp_acc_d;

  logic              out_valid_q;
  logic [WORD_W-1:0] word_q;
  logic [WIDX_W-1:0] windex_q;
  logic [FLEN_W-1:0] flen_q;
  logic              too_long_q;
  logic              last_q;

  logic [WORD_W-1:0] ip_total, udp_len, padded_total;
  logic [WORD_W-1:0] ip_term, udp_term, word_sel;
  logic              emit_go;

  always_comb begin
    ip_total     = HDR_BYTES + job_q.plen;
    udp_len      = UDP_HDR_BYTES + job_q.plen;
    padded_total = ip_total + {{(WORD_W-1){1'b0}}, job_q.plen[0]};

    // IPv4 header words, with the checksum slot at zero while summing.
    case (idx_q)
      W_VER_TOS:   ip_term = IPV4_VER_IHL;
      W_TOTAL_LEN: ip_term = ip_total;
      W_FLAGS:     ip_term = IPV4_FLAGS_DF;
      W_TTL_PROTO: ip_term = {ttl_i, PROTO_UDP};
      W_SRC_HI:    ip_term = local_ip_i[ADDR_W-1:WORD_W];
      W_SRC_LO:    ip_term = local_ip_i[WORD_W-1:0];
      W_DST_HI:    ip_term = job_q.dst_ip[ADDR_W-1:WORD_W];
      W_DST_LO:    ip_term = job_q.dst_ip[WORD_W-1:0];
      default:     ip_term = '0;
    endcase

    // Pseudo header, UDP header and payload, one term per step.
    case (idx_q)
      4'd0:    udp_term = local_ip_i[ADDR_W-1:WORD_W];
      4'd1:    udp_term = local_ip_i[WORD_W-1:0];
      4'd2:    udp_term = job_q.dst_ip[ADDR_W-1:WORD_W];
      4'd3:    udp_term = job_q.dst_ip[WORD_W-1:0];
      4'd4:    udp_term = {{BYTE_W{1'b0}}, PROTO_UDP};
      4'd5:    udp_term = udp_len;
      4'd6:    udp_term = job_q.sport;
      4'd7:    udp_term = job_q.dport;
      4'd8:    udp_term = udp_len;
      4'd9:    udp_term = job_q.pay_sum;
      default: udp_term = '0;
    endcase

    case (idx_q)
      W_IP_CSUM:  word_sel = finish_sum(ip_acc_q);
      W_SPORT:    word_sel = job_q.sport;
      W_DPORT:    word_sel = job_q.dport;
      W_UDP_LEN:  word_sel = udp_len;
      W_UDP_CSUM: word_sel = finish_sum(udp_acc_q);
      default:    word_sel = ip_term;
    endcase
  end

  assign emit_go = (state_q == B_EMIT) && (!out_valid_q || !out_stall_i);
  assign pop_o   = (state_q == B_IDLE) && !q_empty_i;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    ip_acc_d  = ip_acc_q;
    udp_acc_d = udp_acc_q;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          state_d   = B_SUM;
          idx_d     = '0;
          ip_acc_d  = '0;
          udp_acc_d = '0;
        end
      end
      B_SUM: begin
        ip_acc_d  = fold_add(ip_acc_q, ip_term);
        udp_acc_d = fold_add(udp_acc_q, udp_term);
        if (idx_q == LAST_SUM_TERM) begin
          state_d = B_EMIT;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      B_EMIT: begin
        if (emit_go) begin
          if (idx_q == W_UDP_CSUM) begin
            state_d = B_IDLE;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ip_acc_q  <= ip_acc_d;
    udp_acc_q <= udp_acc_d;
    if (pop_o) begin
      job_q <= q_data_i;
    end
    if (emit_go) begin
      word_q     <= word_sel;
      windex_q   <= idx_q;
      flen_q     <= padded_total[FLEN_W-1:0];
      too_long_q <= job_q.too_long;
      last_q     <= (idx_q == W_UDP_CSUM);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign header_word_o  = word_q;
  assign word_index_o   = windex_q;
  assign frame_length_o = flen_q;
  assign too_long_o     = too_long_q;
  assign last_word_o    = last_q;

endmodule

`default_nettype wire

### sv/udp_ipv4_header_builder_core.sv
// UDP over IPv4 header builder.
// Input channel (in_valid_i / in_stall_o): one payload byte per request, with
// has_byte_i low only for an empty packet. The request with last_i high closes
// the packet and supplies the ports and destination address.
// Output channel (out_valid_o / out_stall_i): fourteen 16-bit header words per
// packet in network order, words 0-9 IPv4 and 10-13 UDP; last_word_o marks 13.
// Configuration (cfg_valid_i / cfg_ready_o): index 0 is the local address,
// index 1 the TTL; ready is always high. Write only while the block is idle.
// Throughput: one byte per cycle into the front end while the queue has room;
// the front end keeps the running checksum with a single folding add. The back
// end gathers both checksums and then emits the header words in order, holding
// a word while the output stalls; a two-entry packet queue lets the front end
// keep taking bytes meanwhile.
// in_stall_o rises only while the packet queue is full.
// A stalled receiver holds the current word in the output register; the back
// end waits and the front end continues until the queue fills.
// Reset clears the running sum, counters, queue and output valid; the local
// address resets to zero and the TTL to 64.
`default_nettype none

module udp_ipv4_header_builder_core import uhb_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 1472
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [BYTE_W-1:0]     data_byte_i,
  input  wire logic                  has_byte_i,
  input  wire logic                  last_i,
  input  wire logic [WORD_W-1:0]     sport_i,
  input  wire logic [WORD_W-1:0]     dport_i,
  input  wire logic [ADDR_W-1:0]     dst_ip_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [WORD_W-1:0]          header_word_o,
  output logic [WIDX_W-1:0]          word_index_o,
  output logic [FLEN_W-1:0]          frame_length_o,
  output logic                       too_long_o,
  output logic                       last_word_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [ADDR_W-1:0] local_ip_q;
  logic [BYTE_W-1:0] ttl_q;

  logic      in_accept;
  logic      push, pop, q_full, q_empty;
  pkt_desc_t push_desc, pop_desc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign in_accept   = in_valid_i && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q <= '0;
      ttl_q      <= TTL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_LOCAL_IP: local_ip_q <= cfg_data_i[ADDR_W-1:0];
        REG_TTL:      ttl_q      <= cfg_data_i[BYTE_W-1:0];
        default:      ;
      endcase
    end
  end

  uhb_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (data_byte_i),
    .has_byte_i  (has_byte_i),
    .last_i      (last_i),
    .sport_i     (sport_i),
    .dport_i     (dport_i),
    .dst_ip_i    (dst_ip_i),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  uhb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .pop_i       (pop),
    .pop_data_o  (pop_desc),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  uhb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .local_ip_i     (local_ip_q),
    .ttl_i          (ttl_q),
    .q_empty_i      (q_empty),
    .q_data_i       (pop_desc),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .header_word_o  (header_word_o),
    .word_index_o   (word_index_o),
    .frame_length_o (frame_length_o),
    .too_long_o     (too_long_o),
    .last_word_o    (last_word_o)
  );

endmodule

`default_nettype wire

### sv/uhb_checker.sv
`default_nettype none

module uhb_checker import uhb_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [WORD_W-1:0] header_word_o,
  input wire logic [WIDX_W-1:0] word_index_o,
  input wire logic [FLEN_W-1:0] frame_length_o,
  input wire logic              last_word_o
);

  // A stalled word must be held until it is taken.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(header_word_o) && $stable(word_index_o))
    else $error("header word changed while stalled");

  // The last flag marks the UDP checksum word and no other.
  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == W_UDP_CSUM)))
    else $error("last_word does not match word_index");

  // Fixed IPv4 header fields.
  a_fixed_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((word_index_o != W_VER_TOS) || (header_word_o == IPV4_VER_IHL)) &&
      ((word_index_o != W_IDENT) || (header_word_o == '0)) &&
      ((word_index_o != W_FLAGS) || (header_word_o == IPV4_FLAGS_DF)))
    else $error("fixed IPv4 header word is wrong");

  // The frame length counts a padded, hence even, payload, and the word index stays within the header.
  a_frame_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !frame_length_o[0] && (word_index_o <= W_UDP_CSUM))
    else $error("odd frame length or word index out of range");

endmodule

bind udp_ipv4_header_builder_core uhb_checker u_uhb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .header_word_o  (header_word_o),
  .word_index_o   (word_index_o),
  .frame_length_o (frame_length_o),
  .last_word_o    (last_word_o)
);

`default_nettype wire
